// ===== sv/fsc_pkg.sv =====
`timescale 1ns / 1ps
// fsc_pkg: sizes, codes, command and configuration types for the synapse channel
// used by every module of the block, no dependencies

package fsc_pkg;

   localparam int SYNAPSES    = 64;
   localparam int SYN_W       = 6;
   localparam int EVENT_SLOTS = 256;
   localparam int EV_AW       = 8;
   localparam int FILL_W      = 9;
   localparam int MAX_DELAY   = 1023;
   localparam int DLY_W       = 10;
   localparam int WT_W        = 16;
   localparam int LVL_W       = 24;
   localparam int DEC_W       = 17;
   localparam int MULT_W      = 25;
   localparam int ACC_W       = 48;
   localparam int GAIN_W      = 32;
   localparam int COND_W      = 32;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int DIV_STEPS   = 25;
   localparam int DCNT_W      = 5;

   localparam logic [WT_W-1:0]  WT_RESET = 16'd4096;
   localparam logic [DEC_W-1:0] ONE_Q16  = 17'd65536;

   // request codes on the input channel
   localparam logic [1:0] REQ_SPIKE = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_LOAD  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_FAC_INC  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_DEPR_INC = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_FAC_DEC  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_DEPR_DEC = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_MAX_MULT = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_RISE     = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_FALL     = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_GAIN     = 3'd7;

   typedef enum logic [1:0] {
      CMD_SPIKE,
      CMD_TICK,
      CMD_LOAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [SYN_W-1:0]  syn;
      logic [WT_W-1:0]   weight;
      logic [DLY_W-1:0]  delay;
   } cmd_type;

   typedef struct packed {
      logic [LVL_W-1:0]         fac_inc;
      logic [LVL_W-1:0]         depr_inc;
      logic [DEC_W-1:0]         fac_dec;
      logic [DEC_W-1:0]         depr_dec;
      logic signed [MULT_W-1:0] max_mult;
      logic [DEC_W-1:0]         rise;
      logic [DEC_W-1:0]         fall;
      logic [GAIN_W-1:0]        gain;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_SPK_W,
      ST_SPK_WR,
      ST_TK_EV,
      ST_TK_CHK,
      ST_TK_SYN,
      ST_TK_DIV0,
      ST_TK_DIV,
      ST_TK_MUL,
      ST_TK_ACC,
      ST_TK_FX,
      ST_TK_FX2,
      ST_TK_FY,
      ST_TK_FY2,
      ST_TK_SC,
      ST_TK_SC2,
      ST_DEC_W,
      ST_DEC_M,
      ST_DEC_WR,
      ST_TK_OUT
   } state_type;

endpackage

// ===== sv/fsc_front.sv =====
`timescale 1ns / 1ps
// fsc_front: accepts request words, drops unused codes and bad indexes, forms commands
// depends on fsc_pkg

module fsc_front (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_type,
   input  logic [fsc_pkg::SYN_W-1:0]   req_synapse_index,
   input  logic [fsc_pkg::WT_W-1:0]    req_synapse_weight,
   input  logic [fsc_pkg::DLY_W-1:0]   req_delay_steps,
   input  logic                        queue_full,
   input  logic                        init_done,
   output logic                        push,
   output fsc_pkg::cmd_type            push_cmd
);
   import fsc_pkg::*;

   logic keep;
   logic idx_ok;

   assign req_stall = queue_full || !init_done;
   assign idx_ok    = {1'b0, req_synapse_index} < (SYN_W + 1)'(SYNAPSES);

   always_comb begin
      push_cmd.syn    = req_synapse_index;
      push_cmd.weight = req_synapse_weight;
      push_cmd.delay  = (req_delay_steps > DLY_W'(MAX_DELAY)) ? DLY_W'(MAX_DELAY)
                                                             : req_delay_steps;
      unique case (req_type)
         REQ_SPIKE: begin
            push_cmd.kind = CMD_SPIKE;
            keep          = idx_ok;
         end
         REQ_TICK: begin
            push_cmd.kind = CMD_TICK;
            keep          = 1'b1;
         end
         REQ_LOAD: begin
            push_cmd.kind = CMD_LOAD;
            keep          = idx_ok;
         end
         default: begin
            push_cmd.kind = CMD_TICK;
            keep          = 1'b0;
         end
      endcase
   end

   assign push = req_valid && !req_stall && keep;

endmodule

// ===== sv/fsc_queue.sv =====
`timescale 1ns / 1ps
// fsc_queue: short command queue between the front and the back
// depends on fsc_pkg

module fsc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fsc_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output fsc_pkg::cmd_type head
);
   import fsc_pkg::*;

   cmd_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QCNT_W-1:0]   cnt_ff;

   assign full       = cnt_ff == QCNT_W'(QDEPTH);
   assign head_valid = cnt_ff != '0;
   assign head       = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ===== sv/fsc_back.sv =====
`timescale 1ns / 1ps
// fsc_back: executes commands: event queue, synapse tables, divider, filter, decay sweep
// depends on fsc_pkg

module fsc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  fsc_pkg::cfg_type             cfg,
   input  logic                         cmd_valid,
   input  fsc_pkg::cmd_type             cmd,
   output logic                         cmd_pop,
   output logic                         init_done,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [fsc_pkg::COND_W-1:0]   rsp_conductance,
   output logic                         rsp_spike_dropped,
   output logic [fsc_pkg::FILL_W-1:0]   rsp_pending_count
);
   import fsc_pkg::*;

   state_type state_ff, state_in;

   // memories
   logic [LVL_W-1:0]            fac_mem  [SYNAPSES];
   logic [LVL_W-1:0]            depr_mem [SYNAPSES];
   logic [WT_W+DLY_W-1:0]       par_mem  [SYNAPSES];
   logic [SYN_W+DLY_W-1:0]      ev_mem   [EVENT_SLOTS];

   logic [LVL_W-1:0]            fac_rd_ff, depr_rd_ff;
   logic [WT_W+DLY_W-1:0]       par_rd_ff;
   logic [SYN_W+DLY_W-1:0]      ev_rd_ff;

   logic                        fac_we;
   logic [LVL_W-1:0]            fac_wd, depr_wd;
   logic                        par_we;
   logic [SYN_W-1:0]            par_wa;
   logic [WT_W+DLY_W-1:0]       par_wd;
   logic                        ev_we;
   logic [EV_AW-1:0]            ev_wa;
   logic [SYN_W+DLY_W-1:0]      ev_wd;

   // control and datapath registers
   logic [SYN_W-1:0]            syn_addr_ff;
   logic [FILL_W-1:0]           fill_ff, ev_i_ff, kept_ff;
   logic                        drop_ff;
   logic [ACC_W-1:0]            x_ff, y_ff, xold_ff, act_ff;
   logic [MULT_W-1:0]           rem_ff, den_ff, low_ff, q_ff;
   logic [DCNT_W-1:0]           dcnt_ff;
   logic [WT_W+MULT_W-1:0]      prod_ff;
   logic [39:0]                 pl_ff, ph_ff;
   logic [47:0]                 gph_ff;
   logic [63:0]                 gpl_ff;
   logic [39:0]                 fp_ff, dp_ff;
   logic [COND_W-1:0]           cond_ff;
   logic                        rsp_valid_ff;
   logic [COND_W-1:0]           rsp_cond_ff;
   logic                        rsp_drop_ff;
   logic [FILL_W-1:0]           rsp_pend_ff;

   // combinational helpers
   logic                        full;
   logic                        out_free;
   logic [SYN_W-1:0]            ev_syn;
   logic [DLY_W-1:0]            ev_wait;
   logic [WT_W-1:0]             wt_rd;
   logic [DLY_W-1:0]            dly_rd;
   logic [MULT_W:0]             div_r2;
   logic                        div_ge;
   logic [MULT_W-1:0]           mult;
   logic [LVL_W:0]              fac_sum, depr_sum;
   logic [ACC_W-1:0]            x_dec, y_dec;
   logic [63:0]                 dec_sum;
   logic [ACC_W:0]              filt_sum;
   logic [ACC_W-1:0]            filt_sat;
   logic [64:0]                 sc_sum;
   logic [MULT_W-1:0]           num_hi;

   assign full     = fill_ff == FILL_W'(EVENT_SLOTS);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ev_syn   = ev_rd_ff[SYN_W+DLY_W-1:DLY_W];
   assign ev_wait  = ev_rd_ff[DLY_W-1:0];
   assign wt_rd    = par_rd_ff[WT_W+DLY_W-1:DLY_W];
   assign dly_rd   = par_rd_ff[DLY_W-1:0];
   assign init_done = state_ff != ST_INIT;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_conductance   = rsp_cond_ff;
   assign rsp_spike_dropped = rsp_drop_ff;
   assign rsp_pending_count = rsp_pend_ff;

   // arithmetic
   assign div_r2   = {rem_ff, low_ff[MULT_W-1]};
   assign div_ge   = div_r2 >= {1'b0, den_ff};
   assign num_hi   = MULT_W'({1'b0, fac_rd_ff}) + MULT_W'(ONE_Q16);
   assign fac_sum  = {1'b0, fac_rd_ff} + {1'b0, cfg.fac_inc};
   assign depr_sum = {1'b0, depr_rd_ff} + {1'b0, cfg.depr_inc};
   assign dec_sum  = {ph_ff, 24'd0} + 64'(pl_ff) + 64'd32768;
   assign x_dec    = cfg.rise[DEC_W-1] ? x_ff : dec_sum[63:16];
   assign y_dec    = cfg.fall[DEC_W-1] ? y_ff : dec_sum[63:16];
   assign filt_sum = (state_ff == ST_TK_FX2) ? ({1'b0, act_ff} + {1'b0, x_dec})
                                             : ({1'b0, xold_ff} + {1'b0, y_dec});
   assign filt_sat = filt_sum[ACC_W] ? {ACC_W{1'b1}} : filt_sum[ACC_W-1:0];
   assign sc_sum   = {1'b0, gph_ff, 16'd0} + 65'((65'(gpl_ff) + 65'd32768) >> 16);

   always_comb begin
      mult = q_ff;
      if (!cfg.max_mult[MULT_W-1] && q_ff > MULT_W'(cfg.max_mult)) begin
         mult = MULT_W'(cfg.max_mult);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (syn_addr_ff == SYN_W'(SYNAPSES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_SPIKE: state_in = full ? ST_IDLE : ST_SPK_W;
                  CMD_TICK:  state_in = ST_TK_EV;
                  CMD_LOAD:  state_in = ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SPK_W:   state_in = ST_SPK_WR;
         ST_SPK_WR:  state_in = ST_IDLE;
         ST_TK_EV:   state_in = (ev_i_ff == fill_ff) ? ST_TK_FX : ST_TK_CHK;
         ST_TK_CHK:  state_in = (ev_wait == '0) ? ST_TK_SYN : ST_TK_EV;
         ST_TK_SYN:  state_in = ST_TK_DIV0;
         ST_TK_DIV0: state_in = ST_TK_DIV;
         ST_TK_DIV: begin
            if (dcnt_ff == DCNT_W'(1)) state_in = ST_TK_MUL;
         end
         ST_TK_MUL:  state_in = ST_TK_ACC;
         ST_TK_ACC:  state_in = ST_TK_EV;
         ST_TK_FX:   state_in = ST_TK_FX2;
         ST_TK_FX2:  state_in = ST_TK_FY;
         ST_TK_FY:   state_in = ST_TK_FY2;
         ST_TK_FY2:  state_in = ST_TK_SC;
         ST_TK_SC:   state_in = ST_TK_SC2;
         ST_TK_SC2:  state_in = ST_DEC_W;
         ST_DEC_W:   state_in = ST_DEC_M;
         ST_DEC_M:   state_in = ST_DEC_WR;
         ST_DEC_WR: begin
            state_in = (syn_addr_ff == SYN_W'(SYNAPSES - 1)) ? ST_TK_OUT : ST_DEC_W;
         end
         ST_TK_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_INIT;
      endcase
   end

   // strobes and memory write ports
   always_comb begin
      cmd_pop = 1'b0;
      fac_we  = 1'b0;
      fac_wd  = '0;
      depr_wd = '0;
      par_we  = 1'b0;
      par_wa  = syn_addr_ff;
      par_wd  = {WT_RESET, DLY_W'(0)};
      ev_we   = 1'b0;
      ev_wa   = kept_ff[EV_AW-1:0];
      ev_wd   = {ev_syn, ev_wait - 1'b1};
      unique case (state_ff)
         ST_INIT: begin
            fac_we = 1'b1;
            par_we = 1'b1;
         end
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid && cmd.kind == CMD_LOAD) begin
               par_we = 1'b1;
               par_wa = cmd.syn;
               par_wd = {cmd.weight, cmd.delay};
            end
         end
         ST_SPK_WR: begin
            ev_we = 1'b1;
            ev_wa = fill_ff[EV_AW-1:0];
            ev_wd = {syn_addr_ff, dly_rd};
         end
         ST_TK_CHK: begin
            ev_we = ev_wait != '0;
         end
         ST_TK_MUL: begin
            fac_we  = 1'b1;
            fac_wd  = fac_sum[LVL_W] ? {LVL_W{1'b1}} : fac_sum[LVL_W-1:0];
            depr_wd = depr_sum[LVL_W] ? {LVL_W{1'b1}} : depr_sum[LVL_W-1:0];
         end
         ST_DEC_WR: begin
            fac_we  = 1'b1;
            fac_wd  = cfg.fac_dec[DEC_W-1] ? fac_rd_ff
                                           : LVL_W'((fp_ff + 40'd32768) >> 16);
            depr_wd = cfg.depr_dec[DEC_W-1] ? depr_rd_ff
                                            : LVL_W'((dp_ff + 40'd32768) >> 16);
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (fac_we) begin
         fac_mem[syn_addr_ff]  <= fac_wd;
         depr_mem[syn_addr_ff] <= depr_wd;
      end
      fac_rd_ff  <= fac_mem[syn_addr_ff];
      depr_rd_ff <= depr_mem[syn_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_wa] <= par_wd;
      end
      par_rd_ff <= par_mem[syn_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (ev_we) begin
         ev_mem[ev_wa] <= ev_wd;
      end
      ev_rd_ff <= ev_mem[ev_i_ff[EV_AW-1:0]];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         syn_addr_ff  <= '0;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_TK_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: syn_addr_ff <= syn_addr_ff + 1'b1;
            ST_IDLE: begin
               if (cmd_valid && cmd.kind == CMD_SPIKE) begin
                  syn_addr_ff <= cmd.syn;
                  if (full) drop_ff <= 1'b1;
               end
            end
            ST_SPK_WR: fill_ff <= fill_ff + 1'b1;
            ST_TK_EV: begin
               if (ev_i_ff == fill_ff) fill_ff <= kept_ff;
            end
            ST_TK_CHK: begin
               if (ev_wait == '0) syn_addr_ff <= ev_syn;
            end
            ST_TK_FX2: x_ff <= filt_sat;
            ST_TK_FY2: y_ff <= filt_sat;
            ST_TK_SC2: syn_addr_ff <= '0;
            ST_DEC_WR: syn_addr_ff <= syn_addr_ff + 1'b1;
            ST_TK_OUT: begin
               if (out_free) begin
                  drop_ff <= 1'b0;
               end
            end
            default: begin
               drop_ff <= drop_ff;
            end
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            act_ff  <= '0;
            xold_ff <= x_ff;
            ev_i_ff <= '0;
            kept_ff <= '0;
         end
         ST_TK_CHK: begin
            if (ev_wait != '0) begin
               kept_ff <= kept_ff + 1'b1;
               ev_i_ff <= ev_i_ff + 1'b1;
            end
         end
         ST_TK_DIV0: begin
            rem_ff  <= MULT_W'(num_hi[MULT_W-1:9]);
            low_ff  <= {num_hi[8:0], 16'd0};
            den_ff  <= MULT_W'({1'b0, depr_rd_ff}) + MULT_W'(ONE_Q16);
            q_ff    <= '0;
            dcnt_ff <= DCNT_W'(DIV_STEPS);
         end
         ST_TK_DIV: begin
            rem_ff  <= div_ge ? MULT_W'(div_r2 - {1'b0, den_ff}) : div_r2[MULT_W-1:0];
            q_ff    <= {q_ff[MULT_W-2:0], div_ge};
            low_ff  <= {low_ff[MULT_W-2:0], 1'b0};
            dcnt_ff <= dcnt_ff - 1'b1;
         end
         ST_TK_MUL: prod_ff <= (WT_W + MULT_W)'(wt_rd) * (WT_W + MULT_W)'(mult);
         ST_TK_ACC: begin
            act_ff  <= act_ff + ACC_W'((prod_ff + (WT_W + MULT_W)'(2048)) >> 12);
            ev_i_ff <= ev_i_ff + 1'b1;
         end
         ST_TK_FX: begin
            pl_ff <= 40'(x_ff[23:0]) * 40'(cfg.rise[15:0]);
            ph_ff <= 40'(x_ff[47:24]) * 40'(cfg.rise[15:0]);
         end
         ST_TK_FY: begin
            pl_ff <= 40'(y_ff[23:0]) * 40'(cfg.fall[15:0]);
            ph_ff <= 40'(y_ff[47:24]) * 40'(cfg.fall[15:0]);
         end
         ST_TK_SC: begin
            gph_ff <= 48'(y_ff[47:32]) * 48'(cfg.gain);
            gpl_ff <= 64'(y_ff[31:0]) * 64'(cfg.gain);
         end
         ST_TK_SC2: begin
            cond_ff <= (gph_ff >= 48'd65536 || sc_sum[64:32] != '0) ? {COND_W{1'b1}}
                                                                    : sc_sum[31:0];
         end
         ST_DEC_M: begin
            fp_ff <= 40'(fac_rd_ff) * 40'(cfg.fac_dec[15:0]);
            dp_ff <= 40'(depr_rd_ff) * 40'(cfg.depr_dec[15:0]);
         end
         ST_TK_OUT: begin
            if (out_free) begin
               rsp_cond_ff <= cond_ff;
               rsp_drop_ff <= drop_ff;
               rsp_pend_ff <= fill_ff;
            end
         end
         default: begin
            prod_ff <= prod_ff;
         end
      endcase
   end

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(EVENT_SLOTS))
      else $error("event fill above capacity");

   a_kept_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TK_EV || state_ff == ST_TK_CHK) |-> kept_ff <= ev_i_ff)
      else $error("compaction write ahead of read");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TK_DIV |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_TK_OUT))
      else $error("result word raised outside output state");

endmodule

// ===== sv/facilitating_synapse_channel_core.sv =====
`timescale 1ns / 1ps
// facilitating_synapse_channel_core: top level, configuration registers, front, queue, back
// depends on fsc_pkg, fsc_front, fsc_queue, fsc_back
//
//   channel | ports                              | handshake
//   req     | req_type, req_synapse_*, req_delay | req_valid / req_stall
//   rsp     | rsp_conductance, rsp_spike_dropped | rsp_valid / rsp_stall
//           | rsp_pending_count                  |
//   csr     | csr_index, csr_data                | csr_valid / csr_ready
//
// loads and spikes need no divider; a tick runs the serial divider for each fired event and
// then the decay sweep over all synapse table entries
// after reset the synapse tables are initialised while req_stall is high
// a four word queue lets requests enter while the back part works; a waiting result does
// not block requests until the next tick finishes

module facilitating_synapse_channel_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic [fsc_pkg::SYN_W-1:0]          req_synapse_index,
   input  logic [fsc_pkg::WT_W-1:0]           req_synapse_weight,
   input  logic [fsc_pkg::DLY_W-1:0]          req_delay_steps,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fsc_pkg::COND_W-1:0]         rsp_conductance,
   output logic                               rsp_spike_dropped,
   output logic [fsc_pkg::FILL_W-1:0]         rsp_pending_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fsc_pkg::CSR_AW-1:0]         csr_index,
   input  logic [fsc_pkg::CSR_DW-1:0]         csr_data
);
   import fsc_pkg::*;

   cfg_type          cfg_ff;
   logic [DEC_W-1:0] dec_val;
   logic             push, full, pop, head_valid, init_done;
   cmd_type          push_cmd, head;

   assign csr_ready = 1'b1;
   assign dec_val   = (csr_data[DEC_W-1:0] > ONE_Q16) ? ONE_Q16 : csr_data[DEC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fac_inc  <= '0;
         cfg_ff.depr_inc <= '0;
         cfg_ff.fac_dec  <= ONE_Q16;
         cfg_ff.depr_dec <= ONE_Q16;
         cfg_ff.max_mult <= '1;
         cfg_ff.rise     <= '0;
         cfg_ff.fall     <= '0;
         cfg_ff.gain     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FAC_INC:  cfg_ff.fac_inc  <= csr_data[LVL_W-1:0];
            CSR_DEPR_INC: cfg_ff.depr_inc <= csr_data[LVL_W-1:0];
            CSR_FAC_DEC:  cfg_ff.fac_dec  <= dec_val;
            CSR_DEPR_DEC: cfg_ff.depr_dec <= dec_val;
            CSR_MAX_MULT: cfg_ff.max_mult <= csr_data[MULT_W-1:0];
            CSR_RISE:     cfg_ff.rise     <= dec_val;
            CSR_FALL:     cfg_ff.fall     <= dec_val;
            CSR_GAIN:     cfg_ff.gain     <= csr_data[GAIN_W-1:0];
            default:      cfg_ff.gain     <= cfg_ff.gain;
         endcase
      end
   end

   fsc_front u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_synapse_index  (req_synapse_index),
      .req_synapse_weight (req_synapse_weight),
      .req_delay_steps    (req_delay_steps),
      .queue_full         (full),
      .init_done          (init_done),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   fsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   fsc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd_valid         (head_valid),
      .cmd               (head),
      .cmd_pop           (pop),
      .init_done         (init_done),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_conductance   (rsp_conductance),
      .rsp_spike_dropped (rsp_spike_dropped),
      .rsp_pending_count (rsp_pending_count)
   );

endmodule
